// File: sv/dpd_pkg.sv
// shared constants and helpers for the debug packet deframer
package dpd_pkg;

    localparam int DEF_BUFFER_BYTES = 512;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BREAK = 8'h03;

    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DIGIT1  = 2'd2;
    localparam logic [1:0] PH_DIGIT2  = 2'd3;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_BREAK   = 2'd2;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_digit_t;

    // decode an ascii hex digit, either case
    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        d.bad   = 1'b0;
        d.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            d.value = b[3:0];
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            d.value = b[3:0] + 4'd9;
        end
        else
        begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

// File: sv/debug_packet_deframer.sv
// Deframes $payload#hh remote-debug packets from a received byte stream.
// One byte is taken per clock while rx_stall is low. A byte is held in an input register, decoded
// against the framing state, and its result (payload byte, packet end or
// break request) lands in a result register, so bytes may arrive back to back
// without gaps unless a held result stalls them. Idle bytes other than 0x03,
// '#', the first checksum digit and bytes beyond the buffer limit give no result.
// rx_stall is raised only while a byte waits and a result is held unread under res_stall.
module debug_packet_deframer
    import dpd_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         kind,
    output logic [7:0]         data_byte,
    output logic               checksum_ok,
    output logic               overflowed,
    output logic [COUNT_W-1:0] payload_length
);

    localparam int LIMIT_INT = (BUFFER_BYTES - 1 > 511) ? 511 : BUFFER_BYTES - 1;
    localparam logic [COUNT_W-1:0] PAYLOAD_LIMIT = LIMIT_INT[COUNT_W-1:0];

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;

    logic [1:0]         phase_reg, phase_next;
    logic [7:0]         sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         high_reg, high_next;
    logic               high_bad_reg, high_bad_next;
    logic               ovf_reg, ovf_next;

    logic               res_valid_reg;
    logic [1:0]         kind_reg, kind_next;
    logic [7:0]         data_reg, data_next;
    logic               ok_reg, ok_next;
    logic               ovf_out_reg, ovf_out_next;
    logic [COUNT_W-1:0] len_reg, len_next;
    logic               has_result;

    logic               fire;
    hex_digit_t         digit;

    assign fire     = in_valid_reg && (!res_valid_reg || !res_stall);
    assign rx_stall = in_valid_reg && !fire;
    assign digit    = hex_decode(in_byte_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        high_next     = high_reg;
        high_bad_next = high_bad_reg;
        ovf_next      = ovf_reg;
        has_result    = 1'b0;
        kind_next     = KIND_PAYLOAD;
        data_next     = 8'd0;
        ok_next       = 1'b0;
        ovf_out_next  = 1'b0;
        len_next      = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte_reg == CH_BREAK)
                begin
                    has_result = 1'b1;
                    kind_next  = KIND_BREAK;
                end
                else if (in_byte_reg == CH_START)
                begin
                    phase_next    = PH_PAYLOAD;
                    sum_next      = 8'd0;
                    count_next    = '0;
                    high_next     = 4'd0;
                    high_bad_next = 1'b0;
                    ovf_next      = 1'b0;
                end
            end
            PH_PAYLOAD:
            begin
                if (in_byte_reg == CH_HASH)
                begin
                    phase_next = PH_DIGIT1;
                end
                else
                begin
                    sum_next = sum_reg + in_byte_reg;
                    if (count_reg < PAYLOAD_LIMIT)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                        has_result = 1'b1;
                        kind_next  = KIND_PAYLOAD;
                        data_next  = in_byte_reg;
                    end
                    else
                    begin
                        // buffer full: byte still counts toward the sum
                        ovf_next = 1'b1;
                    end
                end
            end
            PH_DIGIT1:
            begin
                high_next     = digit.value;
                high_bad_next = digit.bad;
                phase_next    = PH_DIGIT2;
            end
            default:
            begin
                phase_next   = PH_IDLE;
                has_result   = 1'b1;
                kind_next    = KIND_END;
                ok_next      = !high_bad_reg && !digit.bad &&
                               ({high_reg, digit.value} == sum_reg);
                ovf_out_next = ovf_reg;
                len_next     = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            sum_reg       <= 8'd0;
            count_reg     <= '0;
            high_reg      <= 4'd0;
            high_bad_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (!rx_stall)
            begin
                in_valid_reg <= rx_valid;
            end
            if (fire)
            begin
                res_valid_reg <= has_result;
                phase_reg     <= phase_next;
                sum_reg       <= sum_next;
                count_reg     <= count_next;
                high_reg      <= high_next;
                high_bad_reg  <= high_bad_next;
                ovf_reg       <= ovf_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!rx_stall && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (fire)
        begin
            kind_reg    <= kind_next;
            data_reg    <= data_next;
            ok_reg      <= ok_next;
            ovf_out_reg <= ovf_out_next;
            len_reg     <= len_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign kind           = kind_reg;
    assign data_byte      = data_reg;
    assign checksum_ok    = ok_reg;
    assign overflowed     = ovf_out_reg;
    assign payload_length = len_reg;

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PAYLOAD_LIMIT)
        else $error("payload count beyond buffer limit");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == PAYLOAD_LIMIT)
        else $error("overflow set before buffer filled");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_DIGIT2) |=> (phase_reg == PH_IDLE && res_valid_reg &&
        kind_reg == KIND_END))
        else $error("second digit did not close the packet");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && kind_reg != KIND_PAYLOAD) |-> data_reg == 8'd0)
        else $error("data byte set on non-payload result");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> (res_valid_reg && $stable(kind_reg) &&
        $stable(len_reg)))
        else $error("held result lost");
`endif

endmodule
